// ----- design/h264foc_pkg.sv -----
// Package for the H.264 frame order control block: field widths, codes,
// sequencer states, saturation helper and the remainder unit status type.
// No dependencies.
package h264foc_pkg;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned FTYPE_W    = 2;
  localparam int unsigned FN_PORT_W  = 16;
  localparam int unsigned LSB_PORT_W = 8;
  localparam int unsigned OC_W       = 18;
  localparam int unsigned SURF_PORT_W = 4;
  localparam int unsigned RC_W       = 5;
  localparam int unsigned IP_W       = 16;
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned STEP_W     = 4;

  localparam logic [IP_W-1:0] IP_RESET = 16'd15;

  localparam logic signed [SUM_W-1:0] OC_MIN = -20'sd131072;
  localparam logic signed [SUM_W-1:0] OC_MAX = 20'sd131071;

  typedef enum logic [REQ_W-1:0] {
    REQ_AUTO   = 2'd0,
    REQ_KEY    = 2'd1,
    REQ_NONKEY = 2'd2,
    REQ_RSVD   = 2'd3
  } frame_req_e;

  typedef enum logic [FTYPE_W-1:0] {
    FT_P   = 2'd0,
    FT_I   = 2'd1,
    FT_IDR = 2'd2
  } frame_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ORDER,
    ST_FINISH
  } seq_state_e;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_status_t;

  function automatic logic signed [OC_W-1:0] sat_oc(input logic signed [SUM_W-1:0] v);
    logic signed [OC_W-1:0] r;
    begin
      if (v < OC_MIN) begin
        r = OC_MIN[OC_W-1:0];
      end else if (v > OC_MAX) begin
        r = OC_MAX[OC_W-1:0];
      end else begin
        r = v[OC_W-1:0];
      end
      return r;
    end
  endfunction

endpackage

// ----- design/h264foc_req_if.sv -----
// Request channel of the frame order control block: valid/ready plus the
// frame request code. Depends on h264foc_pkg.
interface h264foc_req_if;
  logic                            valid;
  logic                            ready;
  logic [h264foc_pkg::REQ_W-1:0]   frame_request;

  modport source (output valid, output frame_request, input ready);
  modport sink   (input valid, input frame_request, output ready);
endinterface

// ----- design/h264foc_res_if.sv -----
// Result channel of the frame order control block: valid/ready plus the
// per-frame picture fields. Depends on h264foc_pkg.
interface h264foc_res_if;
  logic                                     valid;
  logic                                     ready;
  logic [h264foc_pkg::FTYPE_W-1:0]          frame_type;
  logic                                     is_key;
  logic [h264foc_pkg::FN_PORT_W-1:0]        frame_number;
  logic [h264foc_pkg::LSB_PORT_W-1:0]       order_lsb;
  logic signed [h264foc_pkg::OC_W-1:0]      order_count;
  logic [h264foc_pkg::SURF_PORT_W-1:0]      surface_index;
  logic [h264foc_pkg::RC_W-1:0]             ref_count;
  logic                                     ref0_valid;
  logic [h264foc_pkg::SURF_PORT_W-1:0]      ref0_surface;
  logic [h264foc_pkg::FN_PORT_W-1:0]        ref0_frame_number;
  logic signed [h264foc_pkg::OC_W-1:0]      ref0_order_count;

  modport source (output valid, output frame_type, output is_key, output frame_number,
                  output order_lsb, output order_count, output surface_index,
                  output ref_count, output ref0_valid, output ref0_surface,
                  output ref0_frame_number, output ref0_order_count, input ready);
  modport sink   (input valid, input frame_type, input is_key, input frame_number,
                  input order_lsb, input order_count, input surface_index,
                  input ref_count, input ref0_valid, input ref0_surface,
                  input ref0_frame_number, input ref0_order_count, output ready);
endinterface

// ----- design/h264foc_rem_unit.sv -----
// Bit-serial restoring remainder unit: one quotient bit per cycle over a
// 16-bit dividend. Reports busy, done and a zero-remainder flag. Depends on h264foc_pkg.
module h264foc_rem_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [h264foc_pkg::IP_W-1:0]    dividend_i,
  input  logic [h264foc_pkg::IP_W-1:0]    divisor_i,
  output h264foc_pkg::rem_status_t        status_o
);

  logic [h264foc_pkg::IP_W-1:0]   dvd_q, dvd_d;
  logic [h264foc_pkg::IP_W-1:0]   rem_q, rem_d;
  logic [h264foc_pkg::IP_W-1:0]   dsr_q, dsr_d;
  logic [h264foc_pkg::STEP_W-1:0] step_q, step_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [h264foc_pkg::IP_W:0]     trial;

  assign trial = {rem_q, dvd_q[h264foc_pkg::IP_W-1]};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      step_d = '1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // subtract when the trial remainder covers the divisor, else keep it
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = h264foc_pkg::IP_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[h264foc_pkg::IP_W-1:0];
      end
      dvd_d  = {dvd_q[h264foc_pkg::IP_W-2:0], 1'b0};
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign status_o.zero = (rem_q == '0);

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("remainder done without a preceding busy step");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("remainder unit restarted while busy");
  a_busy_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && step_q == '1)
    else $error("remainder unit did not load its step count");
`endif

endmodule

// ----- design/h264_frame_order_control_top.sv -----
// H.264 frame order control, type-0 picture order count.
// Each request passes idle (accept), divide (the 16 bit-serial steps of the
// remainder unit), order and finish; a new request is taken only in idle, so
// not before the previous result has been loaded into the output register.
// A waiting result holds the next request in its finish step until it is taken.
// Reset (async, active low): counters, order count state and handshakes clear,
// intra period returns to 15. Depends on h264foc_pkg, the interfaces, h264foc_rem_unit.
module h264_frame_order_control_top #(
  parameter int unsigned NUM_SURFACES          = 16,
  parameter int unsigned LOG2_MAX_FRAME_NUMBER = 16,
  parameter int unsigned LOG2_MAX_ORDER_LSB    = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [h264foc_pkg::IP_W-1:0] cfg_wdata_i,
  h264foc_req_if.sink                  req_i,
  h264foc_res_if.source                res_o
);

  localparam int unsigned FN_W    = LOG2_MAX_FRAME_NUMBER;
  localparam int unsigned LSB_W   = LOG2_MAX_ORDER_LSB;
  localparam int unsigned SURF_W  = $clog2(NUM_SURFACES);
  localparam int unsigned STC_W   = $clog2(NUM_SURFACES + 1);
  localparam int unsigned MAX_LSB = 1 << LSB_W;
  localparam int unsigned HALF    = MAX_LSB / 2;

  localparam logic signed [h264foc_pkg::SUM_W-1:0] MAX_LSB_S =
    $signed(h264foc_pkg::SUM_W'(MAX_LSB));
  localparam logic [LSB_W:0]    HALF_V    = (LSB_W+1)'(HALF);
  localparam logic [SURF_W-1:0] SURF_LAST = SURF_W'(NUM_SURFACES - 1);
  localparam logic [STC_W-1:0]  STC_FULL  = STC_W'(NUM_SURFACES);

  h264foc_pkg::seq_state_e state_q, state_d;
  h264foc_pkg::rem_status_t rem_st;

  logic [h264foc_pkg::IP_W-1:0]  ip_q;
  logic [FN_W-1:0]               fc_q;
  logic [SURF_W-1:0]             surf_q;
  logic [STC_W-1:0]              stc_q;
  logic signed [h264foc_pkg::OC_W-1:0] pmsb_q;
  logic [LSB_W-1:0]              plsb_q;
  logic [SURF_W-1:0]             ref_surf_q;
  logic [FN_W-1:0]               ref_fn_q;
  logic signed [h264foc_pkg::OC_W-1:0] ref_oc_q;

  logic [h264foc_pkg::REQ_W-1:0] req_q;
  logic                          key_q, key_d;
  logic                          idr_q, idr_d;
  logic signed [h264foc_pkg::OC_W-1:0] msb_q, msb_d;
  logic [LSB_W-1:0]              lsb_q, lsb_d;

  logic                          out_valid_q, out_valid_d;
  logic [h264foc_pkg::FTYPE_W-1:0] o_ftype_q;
  logic                          o_key_q;
  logic [h264foc_pkg::FN_PORT_W-1:0] o_fn_q;
  logic [h264foc_pkg::LSB_PORT_W-1:0] o_lsb_q;
  logic signed [h264foc_pkg::OC_W-1:0] o_oc_q;
  logic [h264foc_pkg::SURF_PORT_W-1:0] o_surf_q;
  logic [h264foc_pkg::RC_W-1:0]  o_rc_q;
  logic                          o_r0v_q;
  logic [h264foc_pkg::SURF_PORT_W-1:0] o_r0s_q;
  logic [h264foc_pkg::FN_PORT_W-1:0] o_r0fn_q;
  logic signed [h264foc_pkg::OC_W-1:0] o_r0oc_q;

  logic                          accept;
  logic                          div_start;
  logic                          load;
  logic [h264foc_pkg::IP_W-1:0]  fc16;
  logic                          auto_key;
  logic signed [h264foc_pkg::OC_W-1:0] pmsb_c;
  logic [LSB_W-1:0]              plsb_c;
  logic [LSB_W-1:0]              up_diff;
  logic [LSB_W-1:0]              dn_diff;
  logic signed [h264foc_pkg::SUM_W-1:0] msb_sum;
  logic signed [h264foc_pkg::OC_W-1:0] poc;
  logic [STC_W-1:0]              stc_base;
  logic                          r0v;
  logic [h264foc_pkg::FTYPE_W-1:0] ftype;

  assign fc16 = h264foc_pkg::IP_W'(fc_q);

  h264foc_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (fc16),
    .divisor_i  (ip_q),
    .status_o   (rem_st)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      h264foc_pkg::ST_IDLE:   if (accept) state_d = h264foc_pkg::ST_DIVIDE;
      h264foc_pkg::ST_DIVIDE: if (rem_st.done) state_d = h264foc_pkg::ST_ORDER;
      h264foc_pkg::ST_ORDER:  state_d = h264foc_pkg::ST_FINISH;
      h264foc_pkg::ST_FINISH: if (load) state_d = h264foc_pkg::ST_IDLE;
      default:                state_d = h264foc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_i.ready = 1'b0;
    load        = 1'b0;
    case (state_q)
      h264foc_pkg::ST_IDLE:   req_i.ready = 1'b1;
      h264foc_pkg::ST_FINISH: load = !out_valid_q || res_o.ready;
      default: begin
        req_i.ready = 1'b0;
        load        = 1'b0;
      end
    endcase
  end

  assign accept      = req_i.valid && req_i.ready;
  assign div_start   = accept;
  assign out_valid_d = load || (out_valid_q && !res_o.ready);

  // key decision and order count MSB
  always_comb begin
    if (ip_q == '0) begin
      auto_key = (fc_q == '0);
    end else begin
      auto_key = rem_st.zero;
    end
    case (req_q)
      h264foc_pkg::REQ_AUTO: key_d = auto_key;
      h264foc_pkg::REQ_KEY:  key_d = 1'b1;
      default:               key_d = 1'b0;
    endcase
    idr_d   = key_d && (fc_q == '0);
    pmsb_c  = idr_d ? '0 : pmsb_q;
    plsb_c  = idr_d ? '0 : plsb_q;
    lsb_d   = fc16[LSB_W-1:0];
    up_diff = plsb_c - lsb_d;
    dn_diff = lsb_d - plsb_c;
    if (lsb_d < plsb_c && {1'b0, up_diff} >= HALF_V) begin
      msb_sum = h264foc_pkg::SUM_W'(pmsb_c) + MAX_LSB_S;
    end else if (lsb_d > plsb_c && {1'b0, dn_diff} > HALF_V) begin
      msb_sum = h264foc_pkg::SUM_W'(pmsb_c) - MAX_LSB_S;
    end else begin
      msb_sum = h264foc_pkg::SUM_W'(pmsb_c);
    end
    msb_d = h264foc_pkg::sat_oc(msb_sum);
  end

  // picture result
  always_comb begin
    poc      = h264foc_pkg::sat_oc(h264foc_pkg::SUM_W'(msb_q)
                                   + $signed(h264foc_pkg::SUM_W'(lsb_q)));
    stc_base = idr_q ? '0 : stc_q;
    r0v      = !key_q && (stc_base != '0);
    if (idr_q) begin
      ftype = h264foc_pkg::FT_IDR;
    end else if (key_q) begin
      ftype = h264foc_pkg::FT_I;
    end else begin
      ftype = h264foc_pkg::FT_P;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= h264foc_pkg::ST_IDLE;
      ip_q        <= h264foc_pkg::IP_RESET;
      fc_q        <= '0;
      surf_q      <= '0;
      stc_q       <= '0;
      pmsb_q      <= '0;
      plsb_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ip_q <= cfg_wdata_i;
      end
      if (load) begin
        pmsb_q <= msb_q;
        plsb_q <= lsb_q;
        stc_q  <= (stc_base == STC_FULL) ? stc_base : stc_base + 1'b1;
        fc_q   <= fc_q + 1'b1;
        // surface slot follows the frame counter, including its wrap
        if (fc_q == '1 || surf_q == SURF_LAST) begin
          surf_q <= '0;
        end else begin
          surf_q <= surf_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i.frame_request;
    end
    if (state_q == h264foc_pkg::ST_ORDER) begin
      key_q <= key_d;
      idr_q <= idr_d;
      msb_q <= msb_d;
      lsb_q <= lsb_d;
    end
    if (load) begin
      ref_surf_q <= surf_q;
      ref_fn_q   <= fc_q;
      ref_oc_q   <= poc;
      o_ftype_q  <= ftype;
      o_key_q    <= key_q;
      o_fn_q     <= h264foc_pkg::FN_PORT_W'(fc_q);
      o_lsb_q    <= h264foc_pkg::LSB_PORT_W'(h264foc_pkg::IP_W'(lsb_q));
      o_oc_q     <= poc;
      o_surf_q   <= h264foc_pkg::SURF_PORT_W'(surf_q);
      o_rc_q     <= h264foc_pkg::RC_W'(stc_base);
      o_r0v_q    <= r0v;
      o_r0s_q    <= r0v ? h264foc_pkg::SURF_PORT_W'(ref_surf_q) : '0;
      o_r0fn_q   <= r0v ? h264foc_pkg::FN_PORT_W'(ref_fn_q) : '0;
      o_r0oc_q   <= r0v ? ref_oc_q : '0;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.frame_type        = o_ftype_q;
  assign res_o.is_key            = o_key_q;
  assign res_o.frame_number      = o_fn_q;
  assign res_o.order_lsb         = o_lsb_q;
  assign res_o.order_count       = o_oc_q;
  assign res_o.surface_index     = o_surf_q;
  assign res_o.ref_count         = o_rc_q;
  assign res_o.ref0_valid        = o_r0v_q;
  assign res_o.ref0_surface      = o_r0s_q;
  assign res_o.ref0_frame_number = o_r0fn_q;
  assign res_o.ref0_order_count  = o_r0oc_q;

`ifndef SYNTHESIS
  a_ref0_only_p: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.ref0_valid |-> res_o.frame_type == h264foc_pkg::FT_P
                                        && res_o.ref_count != '0)
    else $error("reference reported on a key frame or with an empty store");
  a_idr_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.frame_type == h264foc_pkg::FT_IDR |->
      res_o.frame_number == '0 && res_o.ref_count == '0 && res_o.is_key)
    else $error("IDR frame without cleared counters");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready && rem_st.busy)
    else $error("request taken while the previous one is in flight");
  a_store_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stc_q <= STC_FULL)
    else $error("short-term count beyond the surface count");
  a_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_st.done |-> state_q == h264foc_pkg::ST_DIVIDE)
    else $error("remainder completed outside the divide step");
`endif

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for h264_frame_order_control_top: drives frame requests
// over the request channel, predicts every picture and checks each result.
// Depends on h264foc_pkg, h264foc_req_if, h264foc_res_if and the design.
module tb_top;

  localparam int LSB_SPAN  = 1 << h264foc_pkg::LSB_PORT_W;
  localparam int LSB_HALF  = LSB_SPAN / 2;
  localparam int NUM_SLOTS = 1 << h264foc_pkg::SURF_PORT_W;
  localparam int POC_HI    = (1 << (h264foc_pkg::OC_W - 1)) - 1;
  localparam int POC_LO    = -(1 << (h264foc_pkg::OC_W - 1));
  localparam int N_SCRIPT  = 24;

  typedef struct packed {
    h264foc_pkg::frame_type_e                       ftype;
    logic                                           is_key;
    logic [h264foc_pkg::FN_PORT_W-1:0]              number;
    logic [h264foc_pkg::LSB_PORT_W-1:0]             poc_lsb;
    logic signed [h264foc_pkg::OC_W-1:0]            poc;
    logic [h264foc_pkg::SURF_PORT_W-1:0]            slot;
    logic [h264foc_pkg::RC_W-1:0]                   refs;
    logic                                           ref_ok;
    logic [h264foc_pkg::SURF_PORT_W-1:0]            ref_slot;
    logic [h264foc_pkg::FN_PORT_W-1:0]              ref_number;
    logic signed [h264foc_pkg::OC_W-1:0]            ref_poc;
  } picture_t;

  typedef struct {
    bit                              cfg_en;
    logic [h264foc_pkg::IP_W-1:0]    cfg_val;
    h264foc_pkg::frame_req_e         req;
    bit                              typed;
    picture_t                        want;
  } script_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [h264foc_pkg::IP_W-1:0]    cfg_wdata_i;

  h264foc_req_if req_ch ();
  h264foc_res_if res_ch ();

  h264_frame_order_control_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .res_o       (res_ch)
  );

  // Predicted block state
  logic [h264foc_pkg::IP_W-1:0]        gop_len = h264foc_pkg::IP_RESET;
  logic [h264foc_pkg::FN_PORT_W-1:0]   frame_cnt = '0;
  int                                  held_refs = 0;
  int                                  poc_msb = 0;
  int                                  poc_lsb_prev = 0;
  logic [h264foc_pkg::SURF_PORT_W-1:0] store_slot [NUM_SLOTS];
  logic [h264foc_pkg::FN_PORT_W-1:0]   store_number [NUM_SLOTS];
  int                                  store_poc [NUM_SLOTS];

  picture_t pictures_due [$];
  picture_t want_pic;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_off = 0;
  int error_count = 0;
  int pictures_seen = 0;

  // Directed frames; typed rows carry a picture read straight off the rules
  script_row_t script [N_SCRIPT] = '{
    '{0, 0,     h264foc_pkg::REQ_NONKEY, 1,
      '{h264foc_pkg::FT_P,   0, 0,  0,  0,  0,  0,  0, 0,  0,  0}},
    '{0, 0,     h264foc_pkg::REQ_KEY,    1,
      '{h264foc_pkg::FT_I,   1, 1,  1,  1,  1,  1,  0, 0,  0,  0}},
    '{0, 0,     h264foc_pkg::REQ_RSVD,   1,
      '{h264foc_pkg::FT_P,   0, 2,  2,  2,  2,  2,  1, 1,  1,  1}},
    '{0, 0,     h264foc_pkg::REQ_AUTO,   0, '0},
    '{0, 0,     h264foc_pkg::REQ_NONKEY, 0, '0},
    '{0, 0,     h264foc_pkg::REQ_AUTO,   0, '0},
    '{0, 0,     h264foc_pkg::REQ_AUTO,   0, '0},
    '{0, 0,     h264foc_pkg::REQ_RSVD,   0, '0},
    '{0, 0,     h264foc_pkg::REQ_AUTO,   0, '0},
    '{0, 0,     h264foc_pkg::REQ_AUTO,   0, '0},
    '{0, 0,     h264foc_pkg::REQ_NONKEY, 0, '0},
    '{0, 0,     h264foc_pkg::REQ_AUTO,   0, '0},
    '{0, 0,     h264foc_pkg::REQ_AUTO,   0, '0},
    '{0, 0,     h264foc_pkg::REQ_AUTO,   0, '0},
    '{0, 0,     h264foc_pkg::REQ_AUTO,   0, '0},
    '{0, 0,     h264foc_pkg::REQ_AUTO,   1,
      '{h264foc_pkg::FT_I,   1, 15, 15, 15, 15, 15, 0, 0,  0,  0}},
    '{0, 0,     h264foc_pkg::REQ_NONKEY, 1,
      '{h264foc_pkg::FT_P,   0, 16, 16, 16, 0,  16, 1, 15, 15, 15}},
    '{0, 0,     h264foc_pkg::REQ_AUTO,   1,
      '{h264foc_pkg::FT_P,   0, 17, 17, 17, 1,  16, 1, 0,  16, 16}},
    '{1, 0,     h264foc_pkg::REQ_AUTO,   0, '0},
    '{0, 0,     h264foc_pkg::REQ_AUTO,   0, '0},
    '{1, 1,     h264foc_pkg::REQ_AUTO,   1,
      '{h264foc_pkg::FT_I,   1, 20, 20, 20, 4,  16, 0, 0,  0,  0}},
    '{0, 0,     h264foc_pkg::REQ_KEY,    0, '0},
    '{0, 0,     h264foc_pkg::REQ_RSVD,   0, '0},
    '{1, 65535, h264foc_pkg::REQ_AUTO,   0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clip_poc(input int v);
    if (v < POC_LO) begin
      return POC_LO;
    end
    if (v > POC_HI) begin
      return POC_HI;
    end
    return v;
  endfunction

  // Decide the frame type, advance the order count and shift the reference store
  function automatic picture_t next_picture(input h264foc_pkg::frame_req_e r);
    picture_t                          p;
    logic                              key_frame;
    logic [h264foc_pkg::FN_PORT_W-1:0] cnt;
    int                                cur_lsb;
    int                                cur_msb;
    int                                cur_poc;
    int                                i;
    cnt = frame_cnt;
    if (r == h264foc_pkg::REQ_AUTO) begin
      key_frame = (gop_len == '0) ? (cnt == '0) : ((cnt % gop_len) == '0);
    end else begin
      key_frame = (r == h264foc_pkg::REQ_KEY);
    end
    p = '0;
    if (!key_frame) begin
      p.ftype = h264foc_pkg::FT_P;
    end else if (cnt == '0) begin
      p.ftype = h264foc_pkg::FT_IDR;
    end else begin
      p.ftype = h264foc_pkg::FT_I;
    end
    if (p.ftype == h264foc_pkg::FT_IDR) begin
      held_refs = 0;
      poc_msb = 0;
      poc_lsb_prev = 0;
    end
    cur_lsb = cnt % LSB_SPAN;
    cur_msb = poc_msb;
    if (cur_lsb < poc_lsb_prev && poc_lsb_prev - cur_lsb >= LSB_HALF) begin
      cur_msb = cur_msb + LSB_SPAN;
    end else if (cur_lsb > poc_lsb_prev && cur_lsb - poc_lsb_prev > LSB_HALF) begin
      cur_msb = cur_msb - LSB_SPAN;
    end
    cur_msb = clip_poc(cur_msb);
    cur_poc = clip_poc(cur_msb + cur_lsb);
    poc_msb = cur_msb;
    poc_lsb_prev = cur_lsb;

    p.is_key  = key_frame;
    p.number  = cnt;
    p.poc_lsb = cur_lsb[h264foc_pkg::LSB_PORT_W-1:0];
    p.poc     = cur_poc[h264foc_pkg::OC_W-1:0];
    p.slot    = cnt[h264foc_pkg::SURF_PORT_W-1:0];
    p.refs    = held_refs[h264foc_pkg::RC_W-1:0];
    if (p.ftype == h264foc_pkg::FT_P && held_refs > 0) begin
      p.ref_ok     = 1'b1;
      p.ref_slot   = store_slot[0];
      p.ref_number = store_number[0];
      p.ref_poc    = store_poc[0][h264foc_pkg::OC_W-1:0];
    end

    // Drop the oldest reference once the store is full
    if (held_refs < NUM_SLOTS) begin
      held_refs++;
    end
    for (i = held_refs - 1; i > 0; i--) begin
      store_slot[i]   = store_slot[i-1];
      store_number[i] = store_number[i-1];
      store_poc[i]    = store_poc[i-1];
    end
    store_slot[0]   = cnt[h264foc_pkg::SURF_PORT_W-1:0];
    store_number[0] = cnt;
    store_poc[0]    = cur_poc;
    frame_cnt = cnt + 1'b1;
    return p;
  endfunction

  function automatic h264foc_pkg::frame_req_e pick_request();
    int unsigned d;
    d = $urandom_range(99);
    if (d < 50) begin
      return h264foc_pkg::REQ_AUTO;
    end else if (d < 70) begin
      return h264foc_pkg::REQ_KEY;
    end else if (d < 90) begin
      return h264foc_pkg::REQ_NONKEY;
    end
    return h264foc_pkg::REQ_RSVD;
  endfunction

  task automatic report_error(input string msg);
    if (error_count < 100) begin
      $display("ERROR picture %0d: %s", pictures_seen, msg);
    end
    error_count++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report_error($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic offer(input h264foc_pkg::frame_req_e r, input bit typed,
                       input picture_t want);
    picture_t p;
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      req_ch.frame_request <= h264foc_pkg::REQ_W'($urandom);
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.frame_request <= r;
    @(posedge clk_i);
    while (!req_ch.ready) begin
      @(posedge clk_i);
    end
    p = next_picture(r);
    pictures_due.push_back(typed ? want : p);
    @(negedge clk_i);
  endtask

  // Withdraw the request, wait for every picture, then let the pipeline empty
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pictures_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (25) @(negedge clk_i);
  endtask

  task automatic set_gop_length(input logic [h264foc_pkg::IP_W-1:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    gop_len = v;
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [h264foc_pkg::IP_W-1:0] gop, input int idle,
                           input int stall, input int hold, input int n);
    set_gop_length(gop);
    idle_pct = idle;
    stall_pct = stall;
    if (hold > 0) begin
      @(posedge clk_i);
      hold_off = hold;
      @(negedge clk_i);
    end
    repeat (n) offer(pick_request(), 1'b0, '0);
  endtask

  // Result side: hold off for a counted stretch when asked, else stall at random
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        res_ch.ready <= 1'b0;
        hold_off--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pictures_due.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        want_pic = pictures_due.pop_front();
        check_field("frame_type", res_ch.frame_type, want_pic.ftype);
        check_field("is_key", res_ch.is_key, want_pic.is_key);
        check_field("frame_number", res_ch.frame_number, want_pic.number);
        check_field("order_lsb", res_ch.order_lsb, want_pic.poc_lsb);
        check_field("order_count", res_ch.order_count, want_pic.poc);
        check_field("surface_index", res_ch.surface_index, want_pic.slot);
        check_field("ref_count", res_ch.ref_count, want_pic.refs);
        check_field("ref0_valid", res_ch.ref0_valid, want_pic.ref_ok);
        check_field("ref0_surface", res_ch.ref0_surface, want_pic.ref_slot);
        check_field("ref0_frame_number", res_ch.ref0_frame_number, want_pic.ref_number);
        check_field("ref0_order_count", res_ch.ref0_order_count, want_pic.ref_poc);
      end
      pictures_seen++;
    end
  end

  initial begin
    #80_000_000;
    $display("h264_frame_order_control_top: mismatch");
    $finish;
  end

  initial begin
    int k;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_ch.valid = 1'b0;
    req_ch.frame_request = h264foc_pkg::REQ_AUTO;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (k = 0; k < N_SCRIPT; k++) begin
      if (script[k].cfg_en) begin
        set_gop_length(script[k].cfg_val);
      end
      offer(script[k].req, script[k].typed, script[k].want);
    end

    run_phase(16'd15, 0, 0, 0, 220);
    run_phase(16'd1, 88, 0, 0, 220);
    run_phase(16'd0, 0, 88, 0, 220);
    run_phase(h264foc_pkg::IP_W'($urandom_range(40, 2)), 23, 23, 0, 220);
    // Long result hold-off while requests keep coming, so the input backs up
    run_phase(16'd7, 0, 0, 300, 200);
    run_phase(h264foc_pkg::IP_W'($urandom_range(65535, 1)), 23, 23, 0, 220);

    // Longest intra period, then a short mixed tail
    run_phase(16'hFFFF, 0, 0, 0, 0);
    offer(h264foc_pkg::REQ_AUTO, 1'b0, '0);
    offer(h264foc_pkg::REQ_KEY, 1'b0, '0);
    idle_pct = 23;
    stall_pct = 23;
    repeat (20) offer(pick_request(), 1'b0, '0);

    settle();
    repeat (40) @(negedge clk_i);
    if (error_count == 0) begin
      $display("h264_frame_order_control_top: match");
    end else begin
      $display("h264_frame_order_control_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/h264foc_pkg.sv
design/h264foc_req_if.sv
design/h264foc_res_if.sv
design/h264foc_rem_unit.sv
design/h264_frame_order_control_top.sv
bench/tb_top.sv
